// ----- rtl/core/plc_pkg.sv -----
// ----------------------------------------------------------------------------
// plc_pkg
// Types, constants and the boundary test shared by the line clipper modules.
// ----------------------------------------------------------------------------
package plc_pkg;

  localparam int CoordBits = 16;
  localparam int FracBits  = 16;
  localparam int DiffBits  = CoordBits + 1;
  localparam int TBits     = FracBits + 2;
  localparam int QuotBits  = FracBits + 2;
  localparam int DivSteps  = FracBits + 1;
  localparam int DivLat    = DivSteps + 1;
  localparam int ProdBits  = DiffBits + FracBits + 1;
  localparam int NumBnd    = 4;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [DiffBits-1:0]  diff_t;
  typedef logic        [DiffBits-1:0]  mag_t;
  typedef logic signed [TBits-1:0]     tpar_t;
  typedef logic        [ProdBits-1:0]  prod_t;

  localparam tpar_t TZero  = '0;
  localparam tpar_t TOne   = {2'b01, {FracBits{1'b0}}};
  localparam tpar_t TAbove = {2'b01, {(FracBits-1){1'b0}}, 1'b1};
  localparam tpar_t TBelow = '1;

  typedef enum logic [2:0] {
    CLS_PASS,
    CLS_REJECT,
    CLS_ZERO,
    CLS_BELOW,
    CLS_ABOVE,
    CLS_DIV
  } tcls_e;

  typedef enum logic [1:0] {
    REG_CLIP_LEFT,
    REG_CLIP_BOTTOM,
    REG_CLIP_RIGHT,
    REG_CLIP_TOP
  } cfg_reg_e;

  typedef struct packed {
    coord_t              x0;
    coord_t              y0;
    coord_t              x1;
    coord_t              y1;
    diff_t               dx;
    diff_t               dy;
    tcls_e [NumBnd-1:0]  cls;
    logic  [NumBnd-1:0]  p_neg;
  } side_t;

  typedef struct packed {
    logic  ok;
    tpar_t t_in;
    tpar_t t_out;
  } bnd_t;

  function automatic bnd_t bound_step(bnd_t b, tcls_e cls, logic p_neg, tpar_t t);
    bnd_t r;
    r = b;
    if (b.ok) begin
      case (cls)
        CLS_PASS:   r = b;
        CLS_REJECT: r.ok = 1'b0;
        default: begin
          if (p_neg) begin
            if (t > b.t_in) r.t_in = t;
            if (t > b.t_out) r.ok = 1'b0;
          end else begin
            if (t < b.t_out) r.t_out = t;
            if (t < b.t_in) r.ok = 1'b0;
          end
        end
      endcase
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/plc_div.sv -----
// ----------------------------------------------------------------------------
// plc_div
// Pipelined restoring divider, one quotient bit per stage, for num <= den.
// ----------------------------------------------------------------------------
module plc_div
  import plc_pkg::*;
(
  input  logic                clk_i,
  input  logic                en_i,
  input  mag_t                num_i,
  input  mag_t                den_i,
  output logic [QuotBits-1:0] quot_o
);

  logic [DiffBits:0]   rem_q  [DivLat];
  logic [QuotBits-1:0] quot_q [DivLat];
  mag_t                den_q  [DivLat];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q[0] <= den_i;
      if (num_i >= den_i) begin
        rem_q[0]  <= {1'b0, num_i - den_i};
        quot_q[0] <= QuotBits'(1);
      end else begin
        rem_q[0]  <= {1'b0, num_i};
        quot_q[0] <= '0;
      end
    end
  end

  for (genvar k = 1; k < DivLat; k++) begin : g_step
    logic [DiffBits:0] sh;
    logic              ge;
    assign sh = {rem_q[k-1][DiffBits-1:0], 1'b0};
    assign ge = (sh >= {1'b0, den_q[k-1]});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k]  <= den_q[k-1];
        rem_q[k]  <= ge ? sh - {1'b0, den_q[k-1]} : sh;
        quot_q[k] <= {quot_q[k-1][QuotBits-2:0], ge};
      end
    end
  end

  assign quot_o = quot_q[DivLat-1];

endmodule

// ----- rtl/core/parametric_line_clipper.sv -----
// ----------------------------------------------------------------------------
// parametric_line_clipper
// Liang-Barsky clipping of one segment per beat against a register window.
// Throughput: one segment per cycle; the whole pipeline holds while the
// result register waits on m_axis_tready.
// The 18-stage quotient divider sets the depth.
// Reset clears all valid bits and loads the window 50..100 in x and y.
// ----------------------------------------------------------------------------
module parametric_line_clipper
  import plc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // start_x, start_y, end_x, end_y
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y
  output logic [63:0] m_axis_tdata,
  // visible
  output logic [0:0]  m_axis_tuser,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int Lat = DivLat + 7;

  logic   adv;
  coord_t left_q, bottom_q, right_q, top_q;
  logic [Lat-1:0] vld_q;

  assign adv           = !vld_q[Lat-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[Lat-1];
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= coord_t'(50);
      bottom_q <= coord_t'(50);
      right_q  <= coord_t'(100);
      top_q    <= coord_t'(100);
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_CLIP_LEFT:   left_q   <= coord_t'(cfg_data_i);
        REG_CLIP_BOTTOM: bottom_q <= coord_t'(cfg_data_i);
        REG_CLIP_RIGHT:  right_q  <= coord_t'(cfg_data_i);
        REG_CLIP_TOP:    top_q    <= coord_t'(cfg_data_i);
        default:         left_q   <= left_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
    end
  end

  // Stage A: differences.
  coord_t a_x0_q, a_y0_q, a_x1_q, a_y1_q;
  diff_t  a_dx_q, a_dy_q;
  diff_t  a_q_q [NumBnd];
  coord_t in_x0, in_y0, in_x1, in_y1;

  assign in_x0 = s_axis_tdata[15:0];
  assign in_y0 = s_axis_tdata[31:16];
  assign in_x1 = s_axis_tdata[47:32];
  assign in_y1 = s_axis_tdata[63:48];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_x0_q   <= in_x0;
      a_y0_q   <= in_y0;
      a_x1_q   <= in_x1;
      a_y1_q   <= in_y1;
      a_dx_q   <= diff_t'(in_x1) - diff_t'(in_x0);
      a_dy_q   <= diff_t'(in_y1) - diff_t'(in_y0);
      a_q_q[0] <= diff_t'(in_x0) - diff_t'(left_q);
      a_q_q[1] <= diff_t'(right_q) - diff_t'(in_x0);
      a_q_q[2] <= diff_t'(in_y0) - diff_t'(bottom_q);
      a_q_q[3] <= diff_t'(top_q) - diff_t'(in_y0);
    end
  end

  // Stage B: classify each boundary test and set up the division.
  diff_t a_p [NumBnd];
  mag_t  b_ap_d [NumBnd], b_aq_d [NumBnd];
  mag_t  b_ap_q [NumBnd], b_aq_q [NumBnd];
  side_t b_side_d, b_side_q;

  assign a_p[0] = -a_dx_q;
  assign a_p[1] = a_dx_q;
  assign a_p[2] = -a_dy_q;
  assign a_p[3] = a_dy_q;

  always_comb begin
    b_side_d.x0 = a_x0_q;
    b_side_d.y0 = a_y0_q;
    b_side_d.x1 = a_x1_q;
    b_side_d.y1 = a_y1_q;
    b_side_d.dx = a_dx_q;
    b_side_d.dy = a_dy_q;
    for (int i = 0; i < NumBnd; i++) begin
      b_ap_d[i]         = a_p[i][DiffBits-1] ? mag_t'(-a_p[i]) : mag_t'(a_p[i]);
      b_aq_d[i]         = a_q_q[i][DiffBits-1] ? mag_t'(-a_q_q[i]) : mag_t'(a_q_q[i]);
      b_side_d.p_neg[i] = a_p[i][DiffBits-1];
      if (a_p[i] == '0) begin
        b_side_d.cls[i] = a_q_q[i][DiffBits-1] ? CLS_REJECT : CLS_PASS;
      end else if (a_q_q[i] == '0) begin
        b_side_d.cls[i] = CLS_ZERO;
      end else if (a_p[i][DiffBits-1] != a_q_q[i][DiffBits-1]) begin
        b_side_d.cls[i] = CLS_BELOW;
      end else if (b_aq_d[i] > b_ap_d[i]) begin
        b_side_d.cls[i] = CLS_ABOVE;
      end else begin
        b_side_d.cls[i] = CLS_DIV;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_side_q <= b_side_d;
      b_ap_q   <= b_ap_d;
      b_aq_q   <= b_aq_d;
    end
  end

  // Dividers with the side data running beside them.
  logic [QuotBits-1:0] c_quot [NumBnd];
  side_t               c_side_q [DivLat];

  for (genvar i = 0; i < NumBnd; i++) begin : g_div
    plc_div u_div (
      .clk_i  (clk_i),
      .en_i   (adv),
      .num_i  (b_aq_q[i]),
      .den_i  (b_ap_q[i]),
      .quot_o (c_quot[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_side_q[0] <= b_side_q;
      for (int k = 1; k < DivLat; k++) begin
        c_side_q[k] <= c_side_q[k-1];
      end
    end
  end

  // Stage D: quantized ratios.
  side_t d_side_q;
  tpar_t d_t_d [NumBnd], d_t_q [NumBnd];

  always_comb begin
    for (int i = 0; i < NumBnd; i++) begin
      case (c_side_q[DivLat-1].cls[i])
        CLS_BELOW: d_t_d[i] = TBelow;
        CLS_ABOVE: d_t_d[i] = TAbove;
        CLS_DIV:   d_t_d[i] = tpar_t'(({1'b0, c_quot[i]} + (QuotBits+1)'(1)) >> 1);
        default:   d_t_d[i] = TZero;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_side_q <= c_side_q[DivLat-1];
      d_t_q    <= d_t_d;
    end
  end

  // Stages E and F: two boundary tests each.
  side_t e_side_q, f_side_q;
  tpar_t e_t_q [2];
  bnd_t  e_bnd_d, e_bnd_q, f_bnd_d, f_bnd_q;

  always_comb begin
    e_bnd_d = '{ok: 1'b1, t_in: TZero, t_out: TOne};
    e_bnd_d = bound_step(e_bnd_d, d_side_q.cls[0], d_side_q.p_neg[0], d_t_q[0]);
    e_bnd_d = bound_step(e_bnd_d, d_side_q.cls[1], d_side_q.p_neg[1], d_t_q[1]);
    f_bnd_d = bound_step(e_bnd_q, e_side_q.cls[2], e_side_q.p_neg[2], e_t_q[0]);
    f_bnd_d = bound_step(f_bnd_d, e_side_q.cls[3], e_side_q.p_neg[3], e_t_q[1]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_side_q <= d_side_q;
      e_t_q[0] <= d_t_q[2];
      e_t_q[1] <= d_t_q[3];
      e_bnd_q  <= e_bnd_d;
      f_side_q <= e_side_q;
      f_bnd_q  <= f_bnd_d;
    end
  end

  // Stage G: products of parameter and delta magnitudes.
  mag_t  f_adx, f_ady;
  prod_t g_sx_q, g_sy_q, g_ex_q, g_ey_q;
  side_t g_side_q;
  logic  g_vis_q, g_use_s_q, g_use_e_q;

  assign f_adx = f_side_q.dx[DiffBits-1] ? mag_t'(-f_side_q.dx) : mag_t'(f_side_q.dx);
  assign f_ady = f_side_q.dy[DiffBits-1] ? mag_t'(-f_side_q.dy) : mag_t'(f_side_q.dy);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      g_side_q  <= f_side_q;
      g_vis_q   <= f_bnd_q.ok;
      g_use_s_q <= (f_bnd_q.t_in > TZero);
      g_use_e_q <= (f_bnd_q.t_out < TOne);
      g_sx_q    <= f_adx * f_bnd_q.t_in[FracBits:0];
      g_sy_q    <= f_ady * f_bnd_q.t_in[FracBits:0];
      g_ex_q    <= f_adx * f_bnd_q.t_out[FracBits:0];
      g_ey_q    <= f_ady * f_bnd_q.t_out[FracBits:0];
    end
  end

  // Stage H: rounding, sign and offset into the result register.
  function automatic coord_t place(coord_t base, prod_t prod, logic neg);
    prod_t                      rnd;
    logic signed [DiffBits+1:0] off;
    logic signed [DiffBits+1:0] sum;
    rnd = prod + prod_t'({1'b1, {(FracBits-1){1'b0}}});
    off = (DiffBits+2)'(rnd[ProdBits-1:FracBits]);
    if (neg) off = -off;
    sum = (DiffBits+2)'(base) + off;
    return sum[CoordBits-1:0];
  endfunction

  coord_t h_sx_q, h_sy_q, h_ex_q, h_ey_q;
  logic   h_vis_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      h_vis_q <= g_vis_q;
      if (!g_vis_q) begin
        h_sx_q <= '0;
        h_sy_q <= '0;
        h_ex_q <= '0;
        h_ey_q <= '0;
      end else begin
        h_sx_q <= g_use_s_q ?
                  place(g_side_q.x0, g_sx_q, g_side_q.dx[DiffBits-1]) : g_side_q.x0;
        h_sy_q <= g_use_s_q ?
                  place(g_side_q.y0, g_sy_q, g_side_q.dy[DiffBits-1]) : g_side_q.y0;
        h_ex_q <= g_use_e_q ?
                  place(g_side_q.x0, g_ex_q, g_side_q.dx[DiffBits-1]) : g_side_q.x1;
        h_ey_q <= g_use_e_q ?
                  place(g_side_q.y0, g_ey_q, g_side_q.dy[DiffBits-1]) : g_side_q.y1;
      end
    end
  end

  assign m_axis_tdata = {h_ey_q, h_ex_q, h_sy_q, h_sx_q};
  assign m_axis_tuser = h_vis_q;

endmodule

// ----- verif/parametric_line_clipper_tb.sv -----
// ----------------------------------------------------------------------------
// parametric_line_clipper_tb
// Self-checking bench for the Liang-Barsky segment clipper. A queue-fed driver
// offers segments with random gaps, a monitor takes results with random stalls
// and one long hold-off, and each result is checked against a clipping model
// kept in the bench. The window registers go through several settings.
// ----------------------------------------------------------------------------
module parametric_line_clipper_tb
  import plc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint QOne   = 64'sd1 << FracBits;
  localparam longint QAbove = QOne + 1;
  localparam longint QBelow = -1;

  typedef struct {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
  } seg_t;

  typedef struct {
    logic   vis;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
  } clip_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  coord_t win [NumBnd];
  seg_t   seg_q [$];
  clip_t  clip_q [$];
  seg_t   cur_seg;
  int     send_gap;
  int     take_stall;
  int     hold_cnt;
  bit     hold_req;
  bit     hold_done;
  bit     burst;
  int     errors;

  parametric_line_clipper dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic longint quant_ratio(longint p, longint q);
    longint ap, aq, quot, rem;
    if (q == 0) return 0;
    if ((p < 0) != (q < 0)) return QBelow;
    ap = p < 0 ? -p : p;
    aq = q < 0 ? -q : q;
    if (aq > ap) return QAbove;
    rem  = aq;
    quot = 0;
    if (rem >= ap) begin
      quot = 1;
      rem -= ap;
    end
    for (int i = 0; i <= FracBits; i++) begin
      rem  = rem << 1;
      quot = quot << 1;
      if (rem >= ap) begin
        rem -= ap;
        quot |= 1;
      end
    end
    return (quot + 1) >>> 1;
  endfunction

  function automatic bit edge_test(longint p, longint q, inout longint t_in,
                                   inout longint t_out);
    longint t;
    if (p == 0) return q >= 0;
    t = quant_ratio(p, q);
    if (p < 0) begin
      if (t > t_in) t_in = t;
      if (t > t_out) return 1'b0;
    end else begin
      if (t < t_out) t_out = t;
      if (t < t_in) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic longint scale_delta(longint t, longint d);
    longint a, r;
    a = d < 0 ? -d : d;
    r = (a * t + (64'sd1 << (FracBits - 1))) >>> FracBits;
    return d < 0 ? -r : r;
  endfunction

  function automatic clip_t clip_segment(seg_t s);
    clip_t  c;
    longint x0, y0, dx, dy, t_in, t_out;
    bit     ok;
    x0    = s.x0;
    y0    = s.y0;
    dx    = longint'(s.x1) - x0;
    dy    = longint'(s.y1) - y0;
    t_in  = 0;
    t_out = QOne;
    ok = edge_test(-dx, x0 - win[REG_CLIP_LEFT], t_in, t_out);
    if (ok) ok = edge_test(dx, win[REG_CLIP_RIGHT] - x0, t_in, t_out);
    if (ok) ok = edge_test(-dy, y0 - win[REG_CLIP_BOTTOM], t_in, t_out);
    if (ok) ok = edge_test(dy, win[REG_CLIP_TOP] - y0, t_in, t_out);
    c = '{1'b0, 0, 0, 0, 0};
    if (!ok) return c;
    c = '{1'b1, s.x0, s.y0, s.x1, s.y1};
    if (t_out < QOne) begin
      c.ex = coord_t'(x0 + scale_delta(t_out, dx));
      c.ey = coord_t'(y0 + scale_delta(t_out, dy));
    end
    if (t_in > 0) begin
      c.sx = coord_t'(x0 + scale_delta(t_in, dx));
      c.sy = coord_t'(y0 + scale_delta(t_in, dy));
    end
    return c;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) clip_q.push_back(clip_segment(cur_seg));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (seg_q.size() > 0) begin
          cur_seg = seg_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {cur_seg.y1, cur_seg.x1, cur_seg.y0, cur_seg.x0};
          send_gap = burst ? 0 : $urandom_range(0, 3);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    clip_t  want;
    coord_t got [4];
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      take_stall = 0;
      hold_cnt   = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
                m_axis_tdata[63:48]};
        if (clip_q.size() == 0) begin
          $display("%0t: unexpected beat vis=%0b data=%h", $realtime,
                   m_axis_tuser[0], m_axis_tdata);
          errors++;
        end else begin
          want = clip_q.pop_front();
          if (m_axis_tuser[0] !== want.vis || got[0] !== want.sx || got[1] !== want.sy ||
              got[2] !== want.ex || got[3] !== want.ey) begin
            $display("%0t: expected vis=%0b (%0d,%0d)-(%0d,%0d) actual vis=%0b (%0d,%0d)-(%0d,%0d)",
                     $realtime, want.vis, want.sx, want.sy, want.ex, want.ey,
                     m_axis_tuser[0], got[0], got[1], got[2], got[3]);
            errors++;
          end
        end
        take_stall = burst ? 0 : $urandom_range(0, 3);
      end else if (hold_cnt > 0) begin
        hold_cnt--;
      end else if (take_stall > 0) begin
        take_stall--;
      end
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_cnt  = 200;
      end
      m_axis_tready <= (hold_cnt == 0) && (take_stall == 0);
    end
  end

  task automatic set_window(coord_t l, coord_t b, coord_t r, coord_t t);
    coord_t vals [NumBnd];
    vals = '{l, b, r, t};
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_CLIP_LEFT;
    cfg_data_i  <= vals[0];
    for (int i = 0; i < NumBnd; i++) begin
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      win[i] = vals[i];
      if (i < NumBnd - 1) begin
        cfg_index_i <= cfg_reg_e'(i + 1);
        cfg_data_i  <= vals[i + 1];
      end else begin
        cfg_valid_i <= 1'b0;
      end
    end
  endtask

  function automatic coord_t near(coord_t lo, coord_t hi);
    longint span, v;
    span = longint'(hi) - lo;
    if (span < 0) span = -span;
    v = longint'(lo) - span - 4 + longint'($urandom_range(0, 3 * span + 8));
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return coord_t'(v);
  endfunction

  task automatic add_random(int n);
    seg_t s;
    int   kind;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 9);
      s.x0 = near(win[REG_CLIP_LEFT], win[REG_CLIP_RIGHT]);
      s.y0 = near(win[REG_CLIP_BOTTOM], win[REG_CLIP_TOP]);
      s.x1 = near(win[REG_CLIP_LEFT], win[REG_CLIP_RIGHT]);
      s.y1 = near(win[REG_CLIP_BOTTOM], win[REG_CLIP_TOP]);
      case (kind)
        0, 1: begin
          s.x0 = coord_t'($urandom);
          s.y0 = coord_t'($urandom);
          s.x1 = coord_t'($urandom);
          s.y1 = coord_t'($urandom);
        end
        2: s.x1 = s.x0;
        3: s.y1 = s.y0;
        4: begin
          s.x1 = s.x0;
          s.y1 = s.y0;
        end
        default: ;
      endcase
      seg_q.push_back(s);
    end
  endtask

  task automatic drain();
    while (seg_q.size() > 0 || s_axis_tvalid || clip_q.size() > 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  initial begin
    seg_t dir [$];
    coord_t a, b;
    errors      = 0;
    hold_req    = 1'b0;
    hold_done   = 1'b0;
    burst       = 1'b0;
    win         = '{16'sd50, 16'sd50, 16'sd100, 16'sd100};
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_CLIP_LEFT;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Default window 50..100: inside, crossing, outside, points, parallel.
    dir = '{'{60, 60, 90, 90}, '{0, 0, 150, 150}, '{0, 75, 40, 75},
            '{75, 75, 75, 75}, '{10, 75, 10, 75}, '{50, 100, 50, 100},
            '{50, 0, 50, 200}, '{0, 120, 200, 120}, '{101, 0, 101, 200},
            '{150, 150, 0, 0}, '{-32768, -32768, 32767, 32767},
            '{32767, 32767, -32768, -32768}, '{-32768, 32767, 32767, -32768},
            '{0, 75, 200, 76}, '{75, 0, 76, 200}, '{0, 60, 60, 0},
            '{40, 49, 60, 49}, '{99, 101, 101, 99}, '{-32768, 75, 32767, 75},
            '{75, -32768, 75, 32767}, '{0, 0, 3, 3}};
    foreach (dir[i]) seg_q.push_back(dir[i]);
    add_random(300);
    hold_req = 1'b1;
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_window(-32768, -32768, 32767, 32767);
        1: set_window(32767, 32767, -32768, -32768);
        2: set_window(-5, -5, 5, 5);
        3: set_window(20, 30, 20, 30);
        4: set_window(40, 100, 10, 200);
        default: begin
          a = coord_t'($urandom);
          b = coord_t'($urandom);
          set_window(a < b ? a : b, -300, a < b ? b : a, 700);
        end
      endcase
      burst = ph[0];
      seg_q.push_back('{-32768, -32768, 32767, 32767});
      seg_q.push_back('{32767, -32768, -32768, 32767});
      add_random(230);
      drain();
    end
    set_window(50, 50, 100, 100);
    add_random(20);
    drain();

    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
